// ----- rtl/tpc_pkg.sv -----
// shared types, constants and helpers of the terrain pixel colorizer
// used by tpc_ctrl, tpc_datapath and terrain_pixel_colorizer
`default_nettype none

package tpc_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CFG_W  = 13;
    localparam int CFG_AW = 1;
    localparam int WLIM_W = $clog2(MAX_WIDTH + 1);
    localparam int EW_W   = (CFG_W > WLIM_W) ? CFG_W : WLIM_W;
    localparam int EH_W   = CFG_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_AW-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_AW-1:0] REG_MAP_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd512;

    localparam logic signed [15:0] SEA_LEVEL  = -16'sd500;
    localparam logic signed [16:0] ELV_OFFSET = 17'sd500;

    // elevation term: x * 216 / 9251 via reciprocal 391608 = 216 * 1813, shift 24
    localparam logic [7:0]  ELV_SCALE  = 8'd216;
    localparam logic [18:0] ELV_RECIP  = 19'd391608;
    localparam int          ELV_SHIFT  = 24;
    localparam logic [13:0] ELV_DIV    = 14'd9251;

    // rain weight: rain * 1024 / 425 via rain * 9869 >> 12
    localparam logic [13:0] RAIN_RECIP = 14'd9869;
    localparam int          RAIN_SHIFT = 12;

    // ceil(3 * rain / 10) via (3 * rain + 9) * 205 >> 11
    localparam logic [7:0]  CEIL10_RECIP = 8'd205;
    localparam int          CEIL10_SHIFT = 11;

    // slope light: |slope| * 8 / 125 via |slope| * 16778 >> 18
    localparam logic [14:0] SLOPE_RECIP = 15'd16778;
    localparam int          SLOPE_SHIFT = 18;
    localparam logic [15:0] SLOPE_SAT   = 16'd2000;

    localparam int LAT_W     = 8;
    localparam int DIV_STEPS = LAT_W;

    localparam logic [8:0] Q8_ONE = 9'd256;

    localparam logic [7:0] DESERT_RGB [3] = '{8'd238, 8'd211, 8'd117};
    localparam logic [7:0] GREEN_RGB  [3] = '{8'd49,  8'd146, 8'd1};
    localparam logic [7:0] SEA_RGB    [3] = '{8'd27,  8'd40,  8'd75};

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic out_load;
    } tpc_cmd_t;

    typedef struct packed {
        logic last_col;
        logic out_busy;
    } tpc_stat_t;

    function automatic logic [7:0] sat8(input logic [9:0] v);
        logic [7:0] r;
        r = (v > 10'd255) ? 8'd255 : v[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/terrain_pixel_colorizer.sv -----
// terrain_pixel_colorizer: turns a raster stream of elevation and rainfall
// pixels into rgb colors with a sea color, a rain blend toward green, a
// temperature blend toward snow and slope lighting against the pixel above.
// one pixel is in work at a time: it passes capture, four arithmetic stages
// and the output register load before the next input transfer is taken; the
// output register lets the next pixel enter while a color waits. at the start
// of every row, after reset and after any register write, the latitude term
// is recomputed by a shift-subtract divider (load plus 8 quotient bits),
// during which no pixel is taken. the previous row's elevations sit in
// a 4096-entry line store with one read-before-write access per pixel; it is
// not cleared, and row 0 ignores what it reads. depends on tpc_pkg, tpc_ctrl
// and tpc_datapath
`default_nettype none

module terrain_pixel_colorizer
    import tpc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,    // elevation[15:0], rainfall[23:16]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,    // red[7:0], green[15:8], blue[23:16]
    output logic                      m_tlast
);

    tpc_cmd_t  cmd;
    tpc_stat_t stat;

    tpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/tpc_ctrl.sv -----
// controller of the terrain pixel colorizer: sequences the latitude divider,
// the per-pixel datapath and the output register; uses tpc_pkg
`default_nettype none

module tpc_ctrl
    import tpc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_we,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire tpc_stat_t stat,
    output tpc_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_LAT_LOAD,
        ST_LAT_STEP,
        ST_IDLE,
        ST_CALC,
        ST_OUT
    } state_t;

    localparam logic [2:0] STEP_LAST = 3'(DIV_STEPS - 1);
    localparam logic [2:0] CALC_LAST = 3'd3;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       new_row_reg, new_row_next;
    logic       s_tready_reg;
    logic       accept;

    assign accept   = s_tvalid && s_tready_reg;
    assign s_tready = s_tready_reg;

    always_comb begin
        cmd.accept   = accept;
        cmd.div_load = (state_reg == ST_LAT_LOAD);
        cmd.div_step = (state_reg == ST_LAT_STEP);
        cmd.out_load = (state_reg == ST_OUT) && !stat.out_busy;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        new_row_next = new_row_reg;
        unique case (state_reg)
            ST_LAT_LOAD: begin
                if (!cfg_we) begin
                    state_next = ST_LAT_STEP;
                    cnt_next   = '0;
                end
            end
            ST_LAT_STEP: begin
                if (cfg_we) begin
                    state_next = ST_LAT_LOAD;
                end else if (cnt_reg == STEP_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_IDLE: begin
                priority if (accept) begin
                    state_next   = ST_CALC;
                    cnt_next     = '0;
                    new_row_next = stat.last_col || cfg_we;
                end else if (cfg_we) begin
                    state_next = ST_LAT_LOAD;
                end
            end
            ST_CALC: begin
                if (cfg_we) begin
                    new_row_next = 1'b1;
                end
                if (cnt_reg == CALC_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_OUT: begin
                if (cfg_we) begin
                    new_row_next = 1'b1;
                end
                if (!stat.out_busy) begin
                    state_next = (new_row_reg || cfg_we) ? ST_LAT_LOAD : ST_IDLE;
                end
            end
            default: state_next = ST_LAT_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LAT_LOAD;
            cnt_reg      <= '0;
            new_row_reg  <= 1'b0;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            new_row_reg  <= new_row_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready_reg)
        else $error("second transfer taken while a pixel is in flight");

    a_out_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> ##5 (state_reg == ST_OUT))
        else $error("pixel did not reach the output stage in time");

    a_row_end_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && new_row_reg) |=> (state_reg == ST_LAT_LOAD))
        else $error("latitude not recomputed at end of row");

    a_no_ready_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LAT_STEP) |-> !s_tready_reg)
        else $error("ready raised during latitude division");

endmodule

`default_nettype wire

// ----- rtl/tpc_datapath.sv -----
// datapath of the terrain pixel colorizer: config registers, counters, line
// store, latitude divider, color pipeline and output register; uses tpc_pkg
`default_nettype none

module tpc_datapath
    import tpc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tpc_cmd_t             cmd,
    output tpc_stat_t                 stat,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    // configuration and counters
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [EW_W-1:0]  eff_w;
    logic [EH_W-1:0]  eff_h;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             last_col, last_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAP_WIDTH:  width_reg  <= cfg_wdata;
                REG_MAP_HEIGHT: height_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            eff_w = EW_W'(1);
        end else if (EW_W'(width_reg) > EW_W'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = EH_W'(1);
        end else if (height_reg > EH_W'(MAX_HEIGHT)) begin
            eff_h = EH_W'(MAX_HEIGHT);
        end else begin
            eff_h = height_reg;
        end
    end

    assign last_col = (EW_W'(col_reg) + EW_W'(1)) >= eff_w;
    assign last_row = (EH_W'(row_reg) + EH_W'(1)) >= eff_h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // input capture and line store of the previous row
    logic signed [15:0] line_mem [MAX_WIDTH];
    logic signed [15:0] s_elev;
    logic signed [15:0] elev_reg, above_reg;
    logic [7:0]         rain_reg;
    logic               first_row_reg, fe_reg;

    assign s_elev = $signed(s_tdata[15:0]);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            above_reg         <= line_mem[col_reg];
            line_mem[col_reg] <= s_elev;
            elev_reg          <= s_elev;
            rain_reg          <= s_tdata[23:16];
            first_row_reg     <= (row_reg == '0);
            fe_reg            <= last_col && last_row;
        end
    end

    // latitude term, shift-subtract, one quotient bit per step
    logic signed [13:0] lat_diff, lat_abs;
    logic [22:0]        div_num;
    logic [14:0]        div_den;
    logic [22:0]        rem_reg;
    logic [21:0]        dsh_reg;
    logic [LAT_W-1:0]   lat_q_reg;
    logic               lat_sat_reg;
    logic               div_ge;
    logic [LAT_W-1:0]   lat;

    assign lat_diff = $signed({1'b0, row_reg, 1'b0}) - $signed({1'b0, eff_h});
    assign lat_abs  = lat_diff[13] ? -lat_diff : lat_diff;
    assign div_num  = {lat_abs[12:0], 10'b0};
    assign div_den  = 15'(eff_h) * 15'd5;
    assign div_ge   = (23'(dsh_reg) <= rem_reg);
    assign lat      = lat_sat_reg ? {LAT_W{1'b1}} : lat_q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg     <= div_num;
            dsh_reg     <= {div_den, 7'b0};
            lat_sat_reg <= (div_num >= {div_den, 8'b0});
            lat_q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (div_ge) begin
                rem_reg <= rem_reg - 23'(dsh_reg);
            end
            lat_q_reg <= {lat_q_reg[LAT_W-2:0], div_ge};
            dsh_reg   <= dsh_reg >> 1;
        end
    end

    // stage 1: elevation product, rain weight, rain penalty, slope magnitude
    logic signed [16:0] elev_ext, slope, slope_abs;
    logic               land;
    logic [15:0]        elev_off;
    logic [21:0]        pw_prod;
    logic [9:0]         pw_raw;
    logic [9:0]         r3;
    logic [17:0]        c3_prod;
    logic [34:0]        p1_reg;
    logic [22:0]        x216_reg;
    logic [8:0]         pw_reg;
    logic [6:0]         c3_reg;
    logic               slope_neg_reg;
    logic [15:0]        slope_mag_reg;
    logic               sea_reg;

    assign elev_ext  = {elev_reg[15], elev_reg} + ELV_OFFSET;
    assign land      = elev_reg > SEA_LEVEL;
    assign elev_off  = land ? elev_ext[15:0] : '0;
    assign pw_prod   = 22'(rain_reg) * 22'(RAIN_RECIP);
    assign pw_raw    = pw_prod[RAIN_SHIFT+9:RAIN_SHIFT];
    assign r3        = 10'(rain_reg) * 10'd3 + 10'd9;
    assign c3_prod   = 18'(r3) * 18'(CEIL10_RECIP);
    assign slope     = first_row_reg ? '0
                     : ({elev_reg[15], elev_reg} - {above_reg[15], above_reg});
    assign slope_abs = slope[16] ? -slope : slope;

    always_ff @(posedge aclk) begin
        p1_reg        <= 35'(elev_off) * 35'(ELV_RECIP);
        x216_reg      <= 23'(elev_off) * 23'(ELV_SCALE);
        pw_reg        <= (pw_raw > 10'(Q8_ONE)) ? Q8_ONE : pw_raw[8:0];
        c3_reg        <= c3_prod[CEIL10_SHIFT+6:CEIL10_SHIFT];
        slope_neg_reg <= slope[16];
        slope_mag_reg <= slope_abs[15:0];
        sea_reg       <= !land;
    end

    // stage 2: elevation quotient estimate, desert to green blend, light weight
    logic [9:0]  q_est_reg;
    logic [23:0] prod_reg;
    logic [22:0] x216_d;
    logic [7:0]  c1_next [3];
    logic [7:0]  c1_reg [3];
    logic [25:0] slope_prod;
    logic [7:0]  qm;
    logic [8:0]  lw_reg;
    logic [6:0]  c3_d;
    logic        sea_d;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c1_next[i] = sat8(10'(9'((17'(DESERT_RGB[i]) * 17'(Q8_ONE - pw_reg)) >> 8))
                            + 10'(9'((17'(GREEN_RGB[i]) * 17'(pw_reg)) >> 8)));
        end
    end

    assign slope_prod = 26'(slope_mag_reg[10:0]) * 26'(SLOPE_RECIP);
    assign qm = (slope_mag_reg >= SLOPE_SAT) ? 8'd128
              : slope_prod[SLOPE_SHIFT+7:SLOPE_SHIFT];

    always_ff @(posedge aclk) begin
        q_est_reg <= p1_reg[ELV_SHIFT+9:ELV_SHIFT];
        prod_reg  <= 24'(p1_reg[ELV_SHIFT+9:ELV_SHIFT]) * 24'(ELV_DIV);
        x216_d    <= x216_reg;
        c1_reg    <= c1_next;
        lw_reg    <= slope_neg_reg ? (Q8_ONE - 9'(qm)) : (Q8_ONE + 9'(qm));
        c3_d      <= c3_reg;
        sea_d     <= sea_reg;
    end

    // stage 3: elevation term correction, temperature, snow weight
    logic               elv_corr;
    logic [10:0]        elv;
    logic signed [12:0] temp_a;
    logic [7:0]         temp;
    logic [8:0]         tw_reg;
    logic [7:0]         c1_d [3];
    logic [8:0]         lw_d;
    logic               sea_d2;

    assign elv_corr = (24'(x216_d) - prod_reg) >= 24'(ELV_DIV);
    assign elv      = 11'(q_est_reg) + 11'(elv_corr);
    assign temp_a   = 13'sd255 - $signed({5'b0, lat}) - $signed({2'b0, elv})
                    - $signed({6'b0, c3_d});
    assign temp     = (temp_a > 13'sd0) ? temp_a[7:0] : 8'd0;

    always_ff @(posedge aclk) begin
        tw_reg <= temp[7] ? Q8_ONE : {temp, 1'b0};
        c1_d   <= c1_reg;
        lw_d   <= lw_reg;
        sea_d2 <= sea_d;
    end

    // stage 4: blend toward snow
    logic [7:0] c2_next [3];
    logic [7:0] c2_reg [3];
    logic [8:0] lw_d2;
    logic       sea_d3;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c2_next[i] = sat8(10'(9'((17'(c1_d[i]) * 17'(tw_reg)) >> 8))
                            + 10'(9'((17'(8'd255) * 17'(Q8_ONE - tw_reg)) >> 8)));
        end
    end

    always_ff @(posedge aclk) begin
        c2_reg <= c2_next;
        lw_d2  <= lw_d;
        sea_d3 <= sea_d2;
    end

    // stage 5: slope light into the output register
    logic [7:0] lit [3];
    logic [7:0] rgb_reg [3];
    logic       m_tvalid_reg, m_tlast_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lit[i] = sea_d3 ? SEA_RGB[i]
                   : sat8(10'(9'((17'(c2_reg[i]) * 17'(lw_d2)) >> 8)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            rgb_reg     <= lit;
            m_tlast_reg <= fe_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {rgb_reg[2], rgb_reg[1], rgb_reg[0]};
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        stat.last_col = last_col;
        stat.out_busy = m_tvalid_reg && !m_tready;
    end

endmodule

`default_nettype wire

// ----- verif/terrain_pixel_colorizer_tb.sv -----
// self-checking testbench for terrain_pixel_colorizer: directed and random pixel streams,
// colors checked against an in-bench color predictor with its own line store and counters
// depends on tpc_pkg and the terrain_pixel_colorizer rtl
`default_nettype none

module terrain_pixel_colorizer_tb;
    import tpc_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_PIXELS = 730;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    localparam int DRY_TINT [3] = '{238, 211, 117};
    localparam int WET_TINT [3] = '{49, 146, 1};
    localparam int SEA_TINT [3] = '{27, 40, 75};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } color_t;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_WIDTH,
        OP_HEIGHT
    } step_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        logic signed [15:0] value;
        logic [7:0]        rain;
        logic              typed;
        color_t            want;
    } plan_row_t;

    localparam color_t NO_COLOR      = '0;
    localparam color_t SEA_OPEN      = '{8'd27, 8'd40, 8'd75, 1'b0};
    localparam color_t SEA_FRAME_END = '{8'd27, 8'd40, 8'd75, 1'b1};
    localparam color_t SNOW_OPEN     = '{8'd255, 8'd255, 8'd255, 1'b0};

    localparam int PLAN_LEN = 29;
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // reset size 1024 x 512, row 0
        '{OP_PIXEL,  16'sh8000,  8'd0,   1'b1, SEA_OPEN},
        '{OP_PIXEL,  -16'sd500,  8'd255, 1'b1, SEA_OPEN},
        '{OP_PIXEL,  -16'sd499,  8'd0,   1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sd32767, 8'd0,   1'b1, SNOW_OPEN},
        '{OP_PIXEL,  16'sd0,     8'd255, 1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sd100,   8'd128, 1'b0, NO_COLOR},
        '{OP_PIXEL,  -16'sd1,    8'd1,   1'b0, NO_COLOR},
        // shrink to 2 x 3 mid-row: next pixel ends row 0 at once
        '{OP_WIDTH,  16'sd2,     8'd0,   1'b0, NO_COLOR},
        '{OP_HEIGHT, 16'sd3,     8'd0,   1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sd0,     8'd50,  1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sd2000,  8'd20,  1'b0, NO_COLOR},
        '{OP_PIXEL,  -16'sd499,  8'd200, 1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sd0,     8'd90,  1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sh8000,  8'd9,   1'b1, SEA_FRAME_END},
        // zero sizes act as 1 x 1
        '{OP_WIDTH,  16'sd0,     8'd0,   1'b0, NO_COLOR},
        '{OP_HEIGHT, 16'sd0,     8'd0,   1'b0, NO_COLOR},
        '{OP_PIXEL,  -16'sd600,  8'd0,   1'b1, SEA_FRAME_END},
        '{OP_PIXEL,  16'sd500,   8'd200, 1'b0, NO_COLOR},
        // oversized sizes clamp to 4096
        '{OP_WIDTH,  16'sd8191,  8'd0,   1'b0, NO_COLOR},
        '{OP_HEIGHT, 16'sd8191,  8'd0,   1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sd32767, 8'd255, 1'b0, NO_COLOR},
        '{OP_PIXEL,  -16'sd499,  8'd128, 1'b0, NO_COLOR},
        '{OP_WIDTH,  16'sd4096,  8'd0,   1'b0, NO_COLOR},
        '{OP_HEIGHT, 16'sd4096,  8'd0,   1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sd1234,  8'd77,  1'b0, NO_COLOR},
        '{OP_PIXEL,  16'sd8000,  8'd3,   1'b0, NO_COLOR},
        // 1 x 1 mid-row: ends the map at once
        '{OP_WIDTH,  16'sd1,     8'd0,   1'b0, NO_COLOR},
        '{OP_HEIGHT, 16'sd1,     8'd0,   1'b0, NO_COLOR},
        '{OP_PIXEL,  -16'sd1000, 8'd200, 1'b1, SEA_FRAME_END}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // elevation[15:0], rainfall[23:16]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;    // red[7:0], green[15:8], blue[23:16]
    logic                 m_tlast;

    terrain_pixel_colorizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [CFG_W-1:0]   map_w;
    logic [CFG_W-1:0]   map_h;
    logic signed [15:0] line_store [MAX_WIDTH];
    bit                 stored [MAX_WIDTH];
    int                 stored_prefix;
    int                 col_cnt;
    int                 row_cnt;

    color_t expected_colors [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int pixels_sent;
    int colors_seen;
    int frames_seen;
    int settings_used;
    int error_count;
    int reports;
    int cycle_count;
    int hold_left;
    bit hold_done;
    color_t got_color;
    color_t want_color;

    function automatic int eff_size(input logic [CFG_W-1:0] value, input int limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    function automatic color_t predict_color(input logic signed [15:0] elev,
                                             input logic [7:0] rain);
        int w, h, slot, ev, rn, above, d, lat, elv, v, temp, pw, tw, slope, lw;
        int c1, c2, c3;
        int rgb [3];
        bit last_col, last_row;
        color_t c;
        w = eff_size(map_w, MAX_WIDTH);
        h = eff_size(map_h, MAX_HEIGHT);
        ev = elev;
        rn = rain;
        slot = (col_cnt < MAX_WIDTH) ? col_cnt : MAX_WIDTH - 1;
        above = line_store[slot];
        last_col = (col_cnt + 1 >= w);
        last_row = (row_cnt + 1 >= h);
        if (ev <= -500) begin
            rgb = SEA_TINT;
        end else begin
            d = 2 * row_cnt - h;
            if (d < 0) d = -d;
            lat = (d * 1024) / (5 * h);
            elv = ((ev + 500) * 216) / 9251;
            v = 10 * (255 - lat - elv) - 3 * rn;
            temp = (v <= 0) ? 0 : ((v / 10 > 255) ? 255 : v / 10);
            pw = (rn * 1024) / 425;
            if (pw > 256) pw = 256;
            tw = (temp * 512) / 255;
            if (tw > 256) tw = 256;
            slope = (row_cnt == 0) ? 0 : ev - above;
            lw = 256 + (slope * 8) / 125;
            if (lw > 384) lw = 384;
            if (lw < 128) lw = 128;
            for (int i = 0; i < 3; i++) begin
                c1 = ((DRY_TINT[i] * (256 - pw)) >> 8) + ((WET_TINT[i] * pw) >> 8);
                if (c1 > 255) c1 = 255;
                c2 = ((c1 * tw) >> 8) + ((255 * (256 - tw)) >> 8);
                if (c2 > 255) c2 = 255;
                c3 = (c2 * lw) >> 8;
                rgb[i] = (c3 > 255) ? 255 : c3;
            end
        end
        line_store[slot] = elev;
        stored[slot] = 1'b1;
        while (stored_prefix < MAX_WIDTH && stored[stored_prefix]) stored_prefix++;
        c.red = rgb[0][7:0];
        c.green = rgb[1][7:0];
        c.blue = rgb[2][7:0];
        c.frame_end = last_col && last_row;
        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
        return c;
    endfunction

    task automatic send_pixel(input int elev, input int rain, input bit typed,
                              input color_t want);
        int gap;
        color_t predicted;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rain[7:0], elev[15:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_color(elev[15:0], rain[7:0]);
        expected_colors.push_back(typed ? want : predicted);
        pixels_sent++;
    endtask

    task automatic wait_colors_drained();
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_MAP_WIDTH) map_w = value[CFG_W-1:0];
        else map_h = value[CFG_W-1:0];
    endtask

    function automatic void note_error(input string what, input color_t want,
                                       input color_t got);
        error_count++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("%s at color %0d: expected r %0d g %0d b %0d end %0d,",
                     what, colors_seen, want.red, want.green, want.blue, want.frame_end,
                     " got r %0d g %0d b %0d end %0d",
                     got.red, got.green, got.blue, got.frame_end);
        end
    endfunction

    function automatic int pick_size(input int edge_value);
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 24);
        if (r < 80) return $urandom_range(25, 300);
        if (r < 85) return 0;
        if (r < 90) return 4096;
        if (r < 95) return $urandom_range(4097, 8191);
        return edge_value;
    endfunction

    function automatic int pick_elevation();
        int r, slot, base;
        r = $urandom_range(99);
        if (r < 10) return $urandom_range(0, 65535);
        if (r < 20) return $urandom_range(0, 10) - 505;
        if (r < 35) return -int'($urandom_range(501, 3000));
        if (r < 80) return int'($urandom_range(0, 4499)) - 499;
        if (r < 90) return $urandom_range(4000, 32767);
        // around the pixel above, reaching both clamps of the light weight
        slot = (col_cnt < MAX_WIDTH) ? col_cnt : MAX_WIDTH - 1;
        base = line_store[slot] + int'($urandom_range(0, 5000)) - 2500;
        if (base > 32767) base = 32767;
        if (base < -32768) base = -32768;
        return base;
    endfunction

    function automatic int pick_rain();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 30) return 255;
        return $urandom_range(0, 255);
    endfunction

    // receiver: ready pattern, long hold-off, result check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_color = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
            colors_seen++;
            if (m_tlast) frames_seen++;
            if (expected_colors.size() == 0) begin
                note_error("unexpected color", NO_COLOR, got_color);
            end else begin
                want_color = expected_colors.pop_front();
                if (got_color !== want_color) note_error("color mismatch", want_color, got_color);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && colors_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d colors pending", cycle_count,
                     expected_colors.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int w, h, n;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        map_w = WIDTH_RST;
        map_h = HEIGHT_RST;
        col_cnt = 0;
        row_cnt = 0;
        stored_prefix = 0;
        foreach (line_store[i]) begin
            line_store[i] = '0;
            stored[i] = 1'b0;
        end
        tx_idle_pct = 19;
        rx_idle_pct = 77;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_PLAN[i]) begin
            case (DIRECTED_PLAN[i].kind)
                OP_PIXEL: begin
                    send_pixel(DIRECTED_PLAN[i].value, DIRECTED_PLAN[i].rain,
                               DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
                end
                OP_WIDTH: begin
                    wait_colors_drained();
                    write_reg(REG_MAP_WIDTH, DIRECTED_PLAN[i].value);
                    settings_used++;
                end
                default: begin
                    wait_colors_drained();
                    write_reg(REG_MAP_HEIGHT, DIRECTED_PLAN[i].value);
                end
            endcase
        end

        while (pixels_sent < RANDOM_PIXELS + PLAN_LEN) begin
            wait_colors_drained();
            if (pixels_sent >= 500) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (pixels_sent >= 250) begin
                tx_idle_pct = 77;
                rx_idle_pct = 19;
            end
            w = pick_size(1);
            h = pick_size($urandom_range(1, 2));
            // a row past row 0 must only read line store entries already written
            if (eff_size(w[CFG_W-1:0], MAX_WIDTH) > stored_prefix) begin
                if (row_cnt == 0) h = $urandom_range(0, 1);
                else w = $urandom_range(1, stored_prefix);
            end
            write_reg(REG_MAP_WIDTH, w);
            write_reg(REG_MAP_HEIGHT, h);
            settings_used++;
            n = $urandom_range(15, 60);
            repeat (n) send_pixel(pick_elevation(), pick_rain(), 1'b0, NO_COLOR);
        end

        wait_colors_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_colors.size() != 0) error_count++;
        $display("colorizer run: %0d pixels over %0d map sizes, %0d colors checked",
                 pixels_sent, settings_used, colors_seen);
        $display("map ends seen %0d, line store entries filled %0d, errors %0d",
                 frames_seen, stored_prefix, error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
